### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under an active-low reset
`define CCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication under an active-low reset
`define CCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Event codes, reply codes and register indexes of the conveyor cell controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

	localparam int unsigned OP_BITS    = 4;
	localparam int unsigned REPLY_BITS = 4;
	localparam int unsigned CFG_BITS   = 24;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned DT_BITS    = 16;
	localparam int unsigned COUNT_BITS = 8;

	localparam logic [CFG_BITS-1:0] STUCK_TIMEOUT_RST = 24'd50000;
	localparam logic [CFG_BITS-1:0] REMOVAL_DELAY_RST = 24'd1000;

	// Event codes carried by a request
	typedef enum logic [OP_BITS-1:0] {
		OP_TICK      = 4'd0,
		OP_START     = 4'd1,
		OP_ESTOP     = 4'd2,
		OP_PAUSE     = 4'd3,
		OP_RESUME    = 4'd4,
		OP_RESET     = 4'd5,
		OP_CTRLSTOP  = 4'd6,
		OP_PICKACK   = 4'd7,
		OP_DROPREQ   = 4'd8,
		OP_PICKCHK   = 4'd9,
		OP_DROPCHK   = 4'd10,
		OP_JSRELEASE = 4'd11,
		OP_CLEARBTN  = 4'd12,
		OP_STARTBTN  = 4'd13
	} op_t;

	// Reply codes
	typedef enum logic [REPLY_BITS-1:0] {
		RPL_NONE         = 4'd0,
		RPL_START        = 4'd1,
		RPL_ESTOP        = 4'd2,
		RPL_PAUSE        = 4'd3,
		RPL_RESUME       = 4'd4,
		RPL_RESET        = 4'd5,
		RPL_CTRLSTOP     = 4'd6,
		RPL_DROP_ACK     = 4'd7,
		RPL_DROP_NACK    = 4'd8,
		RPL_PICKCHK_ACK  = 4'd9,
		RPL_PICKCHK_NACK = 4'd10,
		RPL_DROPCHK_ACK  = 4'd11,
		RPL_DROPCHK_NACK = 4'd12,
		RPL_FAULT        = 4'd13,
		RPL_PICKUP_REQ   = 4'd14
	} reply_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STUCK_TIMEOUT = 2'd0,
		CFG_REMOVAL_DELAY = 2'd1
	} cfg_idx_t;

endpackage

`default_nettype wire

### rtl/conveyor_cell_controller.sv
// Conveyor cell controller
//
// Requests enter on item_valid / item_stall: op selects a sensor tick, a
// received command or a button release; the sensor levels and elapsed_ticks
// matter for ticks only. Each request gives exactly one result on
// result_valid / result_stall: a reply code and the motor and status values
// as they stand after the request.
// A request is held in the input register, then the flag and timer update
// writes the result register. Throughput is one request per cycle while
// result_stall is low, set by the single update stage; the input register
// can take one more request while a result waits to be taken.
// When the receiver stalls, the result holds, the input register fills and
// item_stall rises until the result is taken.
// cfg_we writes stuck_timeout (index 0) or removal_delay (index 1); write
// them only while no request is in flight.
// arst_n clears all flags, the count, both timers and the motor, and loads
// the register defaults 50000 and 1000.
// ----------------------------------------------------------------------------
// conveyor_cell_controller
// Event-driven belt controller with stuck and removal timers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module conveyor_cell_controller
	import ccc_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = 255,
	parameter int unsigned TIMER_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_BITS-1:0]   cfg_data,
	// request channel
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic [OP_BITS-1:0]    op,
	input  wire logic                  near_sensor,
	input  wire logic                  far_sensor,
	input  wire logic [DT_BITS-1:0]    elapsed_ticks,
	// result channel
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [REPLY_BITS-1:0]      reply,
	output logic                       motor_reverse,
	output logic [COUNT_BITS-1:0]      blocks_on_belt,
	output logic                       running,
	output logic                       paused_now,
	output logic                       emergency_now,
	output logic                       fault_now,
	output logic                       waiting_pickup
);

	localparam int unsigned CMP_W = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
	localparam int unsigned SUM_W = ((TIMER_BITS > DT_BITS) ? TIMER_BITS : DT_BITS) + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_BLOCKS);

	// configuration registers
	logic [CFG_BITS-1:0] stuck_timeout_q, removal_delay_q;

	// input stage
	logic                 valid_s1;
	logic [OP_BITS-1:0]   op_s1;
	logic                 near_s1, far_s1;
	logic [DT_BITS-1:0]   dt_s1;

	// result stage
	logic                  valid_s2;
	logic [REPLY_BITS-1:0] reply_s2;
	logic                  motor_s2;
	logic [COUNT_BITS-1:0] count_s2;
	logic                  running_s2, paused_s2, emergency_s2, fault_s2, waiting_s2;

	// controller state
	logic                  started_q, emergency_q, conv_fault_q, paused_q;
	logic                  drop_lock_q, pickup_acked_q, end_waiting_q, near_seen_q;
	logic                  motor_on_q;
	logic [COUNT_BITS-1:0] block_count_q;
	logic [TIMER_BITS-1:0] stuck_timer_q, removal_timer_q;

	// next state
	logic                  started_n, emergency_n, conv_fault_n, paused_n;
	logic                  drop_lock_n, pickup_acked_n, end_waiting_n, near_seen_n;
	logic                  motor_on_n;
	logic [COUNT_BITS-1:0] block_count_n;
	logic [TIMER_BITS-1:0] stuck_timer_n, removal_timer_n;
	logic [REPLY_BITS-1:0] reply_n;

	logic [SUM_W-1:0]      stuck_sum, removal_sum;
	logic [TIMER_BITS-1:0] stuck_sat, removal_sat;
	logic                  adv;

	// advance the input stage when the result register is free or being taken
	assign adv        = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !adv;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stuck_timeout_q <= STUCK_TIMEOUT_RST;
			removal_delay_q <= REMOVAL_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STUCK_TIMEOUT: stuck_timeout_q <= cfg_data;
				CFG_REMOVAL_DELAY: removal_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1   <= op;
			near_s1 <= near_sensor;
			far_s1  <= far_sensor;
			dt_s1   <= elapsed_ticks;
		end
	end

	// saturating timer sums
	assign stuck_sum   = SUM_W'(stuck_timer_q) + SUM_W'(dt_s1);
	assign removal_sum = SUM_W'(removal_timer_q) + SUM_W'(dt_s1);
	assign stuck_sat   = (|stuck_sum[SUM_W-1:TIMER_BITS]) ? '1 : stuck_sum[TIMER_BITS-1:0];
	assign removal_sat = (|removal_sum[SUM_W-1:TIMER_BITS]) ? '1 : removal_sum[TIMER_BITS-1:0];

	// event decode and state update
	always_comb begin
		started_n       = started_q;
		emergency_n     = emergency_q;
		conv_fault_n    = conv_fault_q;
		paused_n        = paused_q;
		drop_lock_n     = drop_lock_q;
		pickup_acked_n  = pickup_acked_q;
		end_waiting_n   = end_waiting_q;
		near_seen_n     = near_seen_q;
		motor_on_n      = motor_on_q;
		block_count_n   = block_count_q;
		stuck_timer_n   = stuck_timer_q;
		removal_timer_n = removal_timer_q;
		reply_n         = RPL_NONE;

		unique case (op_s1)
			OP_TICK: begin
				if (emergency_q) begin
					motor_on_n = 1'b0;
				end else if (started_q) begin
					// stuck check
					if (block_count_q != '0 && !end_waiting_q) begin
						stuck_timer_n = stuck_sat;
					end else begin
						stuck_timer_n = '0;
					end
					if (block_count_q != '0 && !end_waiting_q && !drop_lock_q &&
							CMP_W'(stuck_sat) > CMP_W'(stuck_timeout_q)) begin
						conv_fault_n = 1'b1;
						emergency_n  = 1'b1;
						motor_on_n   = 1'b0;
						reply_n      = RPL_FAULT;
					end else if (paused_q) begin
						motor_on_n = 1'b0;
					end else begin
						near_seen_n = near_s1;
						if (drop_lock_q) begin
							motor_on_n = 1'b0;
						end
						if (end_waiting_q && !far_s1) begin
							removal_timer_n = removal_sat;
						end else begin
							removal_timer_n = '0;
						end
						// carry, stop at far end, or count a removal
						if (!end_waiting_q && !drop_lock_q && block_count_q != '0 && !far_s1) begin
							motor_on_n = 1'b1;
						end else if (block_count_q != '0 && far_s1) begin
							motor_on_n    = 1'b0;
							end_waiting_n = 1'b1;
							if (!pickup_acked_q) begin
								reply_n = RPL_PICKUP_REQ;
							end
						end else if (end_waiting_q && !far_s1 &&
								CMP_W'(removal_sat) > CMP_W'(removal_delay_q)) begin
							removal_timer_n = '0;
							end_waiting_n   = 1'b0;
							if (block_count_q != '0) begin
								block_count_n = block_count_q - COUNT_BITS'(1);
							end
						end
					end
				end
			end
			OP_START: begin
				started_n = 1'b1;
				reply_n   = RPL_START;
			end
			OP_ESTOP: begin
				emergency_n = 1'b1;
				reply_n     = RPL_ESTOP;
			end
			OP_PAUSE: begin
				paused_n = 1'b1;
				reply_n  = RPL_PAUSE;
			end
			OP_RESUME: begin
				paused_n = 1'b0;
				reply_n  = RPL_RESUME;
			end
			OP_RESET: begin
				emergency_n   = 1'b0;
				conv_fault_n  = 1'b0;
				started_n     = 1'b0;
				block_count_n = '0;
				drop_lock_n   = 1'b0;
				end_waiting_n = 1'b0;
				reply_n       = RPL_RESET;
			end
			OP_CTRLSTOP: begin
				reply_n = RPL_CTRLSTOP;
			end
			OP_PICKACK: begin
				pickup_acked_n = 1'b1;
			end
			OP_DROPREQ: begin
				if (!drop_lock_q) begin
					if (!near_seen_q) begin
						drop_lock_n = 1'b1;
						reply_n     = RPL_DROP_ACK;
					end else begin
						reply_n = RPL_DROP_NACK;
					end
				end
			end
			OP_PICKCHK: begin
				if (!end_waiting_q) begin
					pickup_acked_n = 1'b0;
					reply_n        = RPL_PICKCHK_ACK;
				end else begin
					reply_n = RPL_PICKCHK_NACK;
				end
			end
			OP_DROPCHK: begin
				if (near_seen_q) begin
					drop_lock_n = 1'b0;
					if (block_count_q < COUNT_MAX) begin
						block_count_n = block_count_q + COUNT_BITS'(1);
					end
					reply_n = RPL_DROPCHK_ACK;
				end else begin
					reply_n = RPL_DROPCHK_NACK;
				end
			end
			OP_JSRELEASE: begin
				drop_lock_n = 1'b1;
			end
			OP_CLEARBTN: begin
				motor_on_n    = 1'b0;
				block_count_n = '0;
			end
			OP_STARTBTN: begin
				started_n = 1'b1;
			end
			default: ;
		endcase
	end

	// commit state on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q       <= 1'b0;
			emergency_q     <= 1'b0;
			conv_fault_q    <= 1'b0;
			paused_q        <= 1'b0;
			drop_lock_q     <= 1'b0;
			pickup_acked_q  <= 1'b0;
			end_waiting_q   <= 1'b0;
			near_seen_q     <= 1'b0;
			motor_on_q      <= 1'b0;
			block_count_q   <= '0;
			stuck_timer_q   <= '0;
			removal_timer_q <= '0;
		end else if (adv) begin
			started_q       <= started_n;
			emergency_q     <= emergency_n;
			conv_fault_q    <= conv_fault_n;
			paused_q        <= paused_n;
			drop_lock_q     <= drop_lock_n;
			pickup_acked_q  <= pickup_acked_n;
			end_waiting_q   <= end_waiting_n;
			near_seen_q     <= near_seen_n;
			motor_on_q      <= motor_on_n;
			block_count_q   <= block_count_n;
			stuck_timer_q   <= stuck_timer_n;
			removal_timer_q <= removal_timer_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			reply_s2     <= reply_n;
			motor_s2     <= motor_on_n;
			count_s2     <= block_count_n;
			running_s2   <= started_n && !emergency_n;
			paused_s2    <= paused_n;
			emergency_s2 <= emergency_n;
			fault_s2     <= conv_fault_n;
			waiting_s2   <= end_waiting_n;
		end
	end

	assign result_valid   = valid_s2;
	assign reply          = reply_s2;
	assign motor_reverse  = motor_s2;
	assign blocks_on_belt = count_s2;
	assign running        = running_s2;
	assign paused_now     = paused_s2;
	assign emergency_now  = emergency_s2;
	assign fault_now      = fault_s2;
	assign waiting_pickup = waiting_s2;

	// checks
	`CCC_ASSERT_IMPL(a_fault_has_emergency, clk, arst_n, conv_fault_q, emergency_q)
	`CCC_ASSERT_IMPL(a_count_bounded, clk, arst_n, 1'b1, block_count_q <= COUNT_MAX)
	`CCC_ASSERT_IMPL(a_stall_only_full, clk, arst_n, item_stall, valid_s1 && valid_s2 && result_stall)
	`CCC_ASSERT_NEXT(a_start_sets, clk, arst_n, adv && op_s1 == OP_START, started_q)

endmodule

`default_nettype wire
